[hw/rtl/mpf_pkg.sv]
package mpf_pkg;

  // Widths of the stream fields
  localparam int unsigned ByteW = 8;
  localparam int unsigned TypeW = 4;
  localparam int unsigned LenGroupW = 7;
  localparam int unsigned LenMaxGroups = 4;
  localparam int unsigned AccW = LenGroupW * LenMaxGroups;
  localparam int unsigned LenCntW = 3;

  // Default bound on remaining-length bytes
  localparam int unsigned MaxLengthBytesDef = 4;

  // Control packet types with special framing
  localparam logic [TypeW-1:0] TypeReserved = 4'd0;
  localparam logic [TypeW-1:0] TypePingReq = 4'd12;
  localparam logic [TypeW-1:0] TypePingResp = 4'd13;
  localparam logic [TypeW-1:0] TypeDisconnect = 4'd14;

  typedef enum logic [1:0] {
    PhHeader = 2'd0,
    PhLength = 2'd1,
    PhBody = 2'd2,
    PhShort = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    RoleHeader = 2'd0,
    RoleLength = 2'd1,
    RoleBody = 2'd2
  } role_e;

  typedef enum logic [1:0] {
    ErrNone = 2'd0,
    ErrReservedType = 2'd1,
    ErrZeroLength = 2'd2,
    ErrLengthTooLong = 2'd3
  } err_e;

  // One tagged output word
  typedef struct packed {
    err_e              err;
    role_e             role;
    logic [TypeW-1:0]  ptype;
    logic              last;
    logic [ByteW-1:0]  data;
  } result_t;

endpackage

[hw/rtl/mpf_in_stage.sv]
module mpf_in_stage (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic [mpf_pkg::ByteW-1:0] data_i,
  output logic                     ready_o,
  output logic                     valid_o,
  output logic [mpf_pkg::ByteW-1:0] data_o,
  input  logic                     ready_i
);

  logic                      valid_q;
  logic [mpf_pkg::ByteW-1:0] data_q;

  // Take a new word when empty or when the held word moves on
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o = data_q;

endmodule

[hw/rtl/mpf_framer.sv]
module mpf_framer #(
  parameter int unsigned MaxLengthBytes = mpf_pkg::MaxLengthBytesDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      advance_i,
  input  logic [mpf_pkg::ByteW-1:0] data_i,
  output mpf_pkg::result_t          result_o
);

  localparam logic [mpf_pkg::LenCntW-1:0] MaxCnt = mpf_pkg::LenCntW'(MaxLengthBytes);

  mpf_pkg::phase_e                   phase_q, phase_d;
  logic [mpf_pkg::TypeW-1:0]         type_q, type_d;
  logic [mpf_pkg::AccW-1:0]          acc_q, acc_d;
  logic [mpf_pkg::LenCntW-1:0]       cnt_q, cnt_d;
  logic [mpf_pkg::AccW-1:0]          rem_q, rem_d;

  logic [mpf_pkg::TypeW-1:0]         hdr_type;
  logic [mpf_pkg::AccW-1:0]          group_shifted;
  logic [mpf_pkg::AccW-1:0]          acc_new;
  logic [mpf_pkg::AccW-1:0]          rem_dec;

  assign hdr_type = data_i[mpf_pkg::ByteW-1 -: mpf_pkg::TypeW];
  assign rem_dec = rem_q - mpf_pkg::AccW'(1);

  // Place the seven value bits at their group position
  always_comb begin
    group_shifted = mpf_pkg::AccW'(data_i[mpf_pkg::LenGroupW-1:0]);
    case (cnt_q[1:0])
      2'd0: group_shifted = group_shifted;
      2'd1: group_shifted = group_shifted << mpf_pkg::LenGroupW;
      2'd2: group_shifted = group_shifted << (2 * mpf_pkg::LenGroupW);
      default: group_shifted = group_shifted << (3 * mpf_pkg::LenGroupW);
    endcase
  end

  assign acc_new = acc_q | group_shifted;

  // Next state and word tags
  always_comb begin
    phase_d = phase_q;
    type_d = type_q;
    acc_d = acc_q;
    cnt_d = cnt_q;
    rem_d = rem_q;
    result_o.data = data_i;
    result_o.ptype = type_q;
    result_o.role = mpf_pkg::RoleHeader;
    result_o.last = 1'b0;
    result_o.err = mpf_pkg::ErrNone;

    unique case (phase_q)
      mpf_pkg::PhHeader: begin
        type_d = hdr_type;
        result_o.ptype = hdr_type;
        unique case (hdr_type) inside
          mpf_pkg::TypeReserved: begin
            result_o.err = mpf_pkg::ErrReservedType;
            result_o.last = 1'b1;
          end
          mpf_pkg::TypePingReq, mpf_pkg::TypePingResp, mpf_pkg::TypeDisconnect: begin
            phase_d = mpf_pkg::PhShort;
          end
          default: begin
            acc_d = '0;
            cnt_d = '0;
            phase_d = mpf_pkg::PhLength;
          end
        endcase
      end
      mpf_pkg::PhShort: begin
        result_o.role = mpf_pkg::RoleLength;
        result_o.last = 1'b1;
        phase_d = mpf_pkg::PhHeader;
      end
      mpf_pkg::PhLength: begin
        result_o.role = mpf_pkg::RoleLength;
        if (cnt_q >= MaxCnt) begin
          // All allowed length bytes carried the continuation bit
          result_o.err = mpf_pkg::ErrLengthTooLong;
          result_o.last = 1'b1;
          phase_d = mpf_pkg::PhHeader;
        end else begin
          acc_d = acc_new;
          cnt_d = cnt_q + mpf_pkg::LenCntW'(1);
          if (!data_i[mpf_pkg::ByteW-1]) begin
            if (acc_new == '0) begin
              result_o.err = mpf_pkg::ErrZeroLength;
              result_o.last = 1'b1;
              phase_d = mpf_pkg::PhHeader;
            end else begin
              rem_d = acc_new;
              phase_d = mpf_pkg::PhBody;
            end
          end
        end
      end
      default: begin
        result_o.role = mpf_pkg::RoleBody;
        rem_d = rem_dec;
        if (rem_dec == '0) begin
          result_o.last = 1'b1;
          phase_d = mpf_pkg::PhHeader;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= mpf_pkg::PhHeader;
      type_q <= '0;
      acc_q <= '0;
      cnt_q <= '0;
      rem_q <= '0;
    end else if (advance_i) begin
      phase_q <= phase_d;
      type_q <= type_d;
      acc_q <= acc_d;
      cnt_q <= cnt_d;
      rem_q <= rem_d;
    end
  end

endmodule

[hw/rtl/mpf_out_stage.sv]
module mpf_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  mpf_pkg::result_t result_i,
  output logic             ready_o,
  output logic             valid_o,
  output mpf_pkg::result_t result_o,
  input  logic             ready_i
);

  logic             valid_q;
  mpf_pkg::result_t result_q;

  // Load when empty or when the held word is taken
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o = valid_q;
  assign result_o = result_q;

endmodule

[hw/rtl/mqtt_packet_framer.sv]
// Pipeline: input register, framing logic, result register, in that order.
// Throughput: one word per cycle while m_axis_tready does not stall.
// Backpressure from m_axis_tready reaches s_axis_tready in the same cycle.
// Reset (rst_ni low, asynchronous): both stages empty, framer expects a header byte.
module mqtt_packet_framer #(
  parameter int unsigned MAX_LENGTH_BYTES = mpf_pkg::MaxLengthBytesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic [7:0] m_axis_tuser,   // [3:0] packet_type, [5:4] byte_role, [7:6] frame_error
  output logic       m_axis_tlast    // last_of_packet
);

  logic                      in_valid;
  logic [mpf_pkg::ByteW-1:0] in_data;
  logic                      out_ready;
  logic                      advance;
  mpf_pkg::result_t          tag_result;
  mpf_pkg::result_t          out_result;

  mpf_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .data_i  (s_axis_tdata),
    .ready_o (s_axis_tready),
    .valid_o (in_valid),
    .data_o  (in_data),
    .ready_i (out_ready)
  );

  // Advance the framing state when a word moves into the result register
  assign advance = in_valid && out_ready;

  mpf_framer #(
    .MaxLengthBytes (MAX_LENGTH_BYTES)
  ) u_framer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .data_i    (in_data),
    .result_o  (tag_result)
  );

  mpf_out_stage u_out_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_valid),
    .result_i (tag_result),
    .ready_o  (out_ready),
    .valid_o  (m_axis_tvalid),
    .result_o (out_result),
    .ready_i  (m_axis_tready)
  );

  assign m_axis_tdata = out_result.data;
  assign m_axis_tuser = {out_result.err, out_result.role, out_result.ptype};
  assign m_axis_tlast = out_result.last;

  // Any error ends the frame on that word
  a_err_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (out_result.err != mpf_pkg::ErrNone) |-> m_axis_tlast)
    else $error("frame error without end of frame");

  // Reserved-type error only on a header word of type zero
  a_reserved_on_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (out_result.err == mpf_pkg::ErrReservedType) |->
      (out_result.role == mpf_pkg::RoleHeader) &&
      (out_result.ptype == mpf_pkg::TypeReserved))
    else $error("reserved-type error on a non-header word");

  // Length errors only on remaining-length words
  a_len_err_role: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && ((out_result.err == mpf_pkg::ErrZeroLength) ||
      (out_result.err == mpf_pkg::ErrLengthTooLong)) |->
      (out_result.role == mpf_pkg::RoleLength))
    else $error("length error outside the length field");

  // Body words carry no error
  a_body_no_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (out_result.role == mpf_pkg::RoleBody) |->
      (out_result.err == mpf_pkg::ErrNone))
    else $error("error flagged on a body word");

endmodule
